>>> sv/cbsm_pkg.sv
// Shared types and codes for the channel block sequence monitor.
package cbsm_pkg;

   localparam int MODE_W        = 2;
   localparam int SLOT_W        = 4;
   localparam int CHANNEL_W     = 4;
   localparam int KEY_W         = SLOT_W + CHANNEL_W;
   localparam int SEQ_REQ_W     = 8;
   localparam int STATUS_W      = 2;
   localparam int ENTRY_INDEX_W = 5;
   localparam int COUNT_W       = 32;
   localparam int MARKS_W       = 2;

   // Transaction modes
   localparam logic [MODE_W-1:0] MODE_RECORD = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_UPDATED   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NEW       = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

   // Bit positions inside the marks field
   localparam int MARK_UPD_BIT = 0;
   localparam int MARK_GAP_BIT = 1;

   // Request token that walks the cell chain, picking up its result on the way
   typedef struct packed {
      logic                     valid;
      logic                     done;
      logic [MODE_W-1:0]        mode;
      logic [KEY_W-1:0]         key;
      logic                     is_daq;
      logic [SEQ_REQ_W-1:0]     seq;
      logic [STATUS_W-1:0]      status;
      logic [ENTRY_INDEX_W-1:0] index;
      logic [COUNT_W-1:0]       blocks;
      logic [COUNT_W-1:0]       lost;
      logic [MARKS_W-1:0]       marks;
   } token_type;

   // Result transaction as held in the output register
   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [ENTRY_INDEX_W-1:0] entry_index;
      logic [COUNT_W-1:0]       block_count;
      logic [COUNT_W-1:0]       lost_count;
      logic                     gap_seen;
      logic                     updated_seen;
   } rsp_type;

endpackage

>>> sv/cbsm_if.sv
// Valid/ready channel interfaces for request and response transactions.
interface cbsm_req_if;
   import cbsm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [MODE_W-1:0]     mode;
   logic [SLOT_W-1:0]     slot;
   logic [CHANNEL_W-1:0]  channel;
   logic                  is_daq;
   logic [SEQ_REQ_W-1:0]  sequence_req;

   modport source (output valid, mode, slot, channel, is_daq, sequence_req, input ready);
   modport sink   (input valid, mode, slot, channel, is_daq, sequence_req, output ready);
endinterface

interface cbsm_rsp_if;
   import cbsm_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic [ENTRY_INDEX_W-1:0] entry_index;
   logic [COUNT_W-1:0]       block_count;
   logic [COUNT_W-1:0]       lost_count;
   logic                     gap_seen;
   logic                     updated_seen;

   modport source (output valid, status, entry_index, block_count, lost_count, gap_seen,
                   updated_seen, input ready);
   modport sink   (input valid, status, entry_index, block_count, lost_count, gap_seen,
                   updated_seen, output ready);
endinterface

>>> sv/cbsm_cell.sv
// One table entry of the monitor chain: holds the entry and serves the passing token.
module cbsm_cell #(
   parameter int INDEX    = 0,
   parameter int SEQ_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  cbsm_pkg::token_type tok_up,
   output cbsm_pkg::token_type tok_dn
);
   import cbsm_pkg::*;

   logic                 valid_ff, valid_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [COUNT_W-1:0]   blocks_ff, blocks_in;
   logic [COUNT_W-1:0]   lost_ff, lost_in;
   logic [SEQ_BITS-1:0]  last_seq_ff, last_seq_in;
   logic [MARKS_W-1:0]   marks_ff, marks_in;
   token_type            tok_ff, tok_in;

   logic                 hit;
   logic [SEQ_BITS-1:0]  seq_now;
   logic [SEQ_BITS-1:0]  expect_seq;
   logic [COUNT_W-1:0]   blocks_inc;
   logic [COUNT_W-1:0]   lost_inc;

   assign hit        = valid_ff && (key_ff == tok_up.key);
   assign seq_now    = SEQ_BITS'(tok_up.seq);
   assign expect_seq = last_seq_ff + SEQ_BITS'(1'b1);
   // saturating increments
   assign blocks_inc = (blocks_ff == '1) ? blocks_ff : blocks_ff + COUNT_W'(1'b1);
   assign lost_inc   = (lost_ff == '1) ? lost_ff : lost_ff + COUNT_W'(1'b1);

   // Serve the token: update, allocate, read or clear this entry
   always_comb begin
      valid_in    = valid_ff;
      key_in      = key_ff;
      blocks_in   = blocks_ff;
      lost_in     = lost_ff;
      last_seq_in = last_seq_ff;
      marks_in    = marks_ff;
      tok_in      = tok_up;
      if (tok_up.valid) begin
         case (tok_up.mode)
            MODE_RECORD: begin
               if (!tok_up.done && hit) begin
                  blocks_in              = blocks_inc;
                  marks_in[MARK_UPD_BIT] = 1'b1;
                  if (tok_up.is_daq) begin
                     if (seq_now != expect_seq) begin
                        marks_in[MARK_GAP_BIT] = 1'b1;
                        lost_in                = lost_inc;
                     end
                     last_seq_in = seq_now;
                  end
                  tok_in.done   = 1'b1;
                  tok_in.status = STATUS_UPDATED;
                  tok_in.index  = ENTRY_INDEX_W'(INDEX);
                  tok_in.blocks = blocks_in;
                  tok_in.lost   = lost_in;
                  tok_in.marks  = marks_in;
               end else if (!tok_up.done && !valid_ff) begin
                  // first free entry: all earlier entries were checked already
                  valid_in    = 1'b1;
                  key_in      = tok_up.key;
                  blocks_in   = COUNT_W'(1'b1);
                  lost_in     = '0;
                  last_seq_in = seq_now;
                  marks_in    = '0;
                  marks_in[MARK_UPD_BIT] = 1'b1;
                  tok_in.done   = 1'b1;
                  tok_in.status = STATUS_NEW;
                  tok_in.index  = ENTRY_INDEX_W'(INDEX);
                  tok_in.blocks = blocks_in;
                  tok_in.lost   = '0;
                  tok_in.marks  = marks_in;
               end
            end
            MODE_READ: begin
               if (!tok_up.done && hit) begin
                  tok_in.done   = 1'b1;
                  tok_in.status = STATUS_UPDATED;
                  tok_in.index  = ENTRY_INDEX_W'(INDEX);
                  tok_in.blocks = blocks_ff;
                  tok_in.lost   = lost_ff;
                  tok_in.marks  = marks_ff;
                  marks_in      = '0;
               end
            end
            MODE_CLEAR: begin
               valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // Hold entry and token; advance when the chain is enabled
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else if (en) begin
         valid_ff    <= valid_in;
         key_ff      <= key_in;
         blocks_ff   <= blocks_in;
         lost_ff     <= lost_in;
         last_seq_ff <= last_seq_in;
         marks_ff    <= marks_in;
         tok_ff      <= tok_in;
      end
   end

   assign tok_dn = tok_ff;

endmodule

>>> sv/channel_block_sequence_monitor.sv
// Top level of the channel block sequence monitor: cell chain plus output register.
//
// Each request transaction (record, read, clear) enters a row of CAPACITY cells, one table
// entry per cell, and moves one cell per clock; the cell holding the matching key, or the
// first free cell for a new key, serves it on the way. The response is registered once the
// token has passed all CAPACITY cells, and the next request is taken only after that, so
// the block takes no new request while one is in the chain. A response the sink does not
// take stalls the chain; a new request may still be accepted once the previous result sits
// in the output register. Entries fill in order of first arrival; clear mode empties the
// table. Block and lost counts saturate at all ones, and sequence numbers compare modulo
// 2**SEQ_BITS. No clearing pass is needed after reset.
module channel_block_sequence_monitor #(
   parameter int CAPACITY = 32,
   parameter int SEQ_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   cbsm_req_if.sink    req_ch,
   cbsm_rsp_if.source  rsp_ch
);
   import cbsm_pkg::*;

   token_type          chain [CAPACITY+1];
   token_type          head;
   logic [CAPACITY:0]  tok_valid_vec;
   token_type          tail;
   logic               en;
   logic               stall;
   logic               busy_ff, busy_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // Stall the chain while a finished token cannot move to the output register
   assign tail  = chain[CAPACITY];
   assign stall = tail.valid && rsp_valid_ff && !rsp_ch.ready;
   assign en    = !stall;

   assign req_ch.ready = !busy_ff;

   // Build the injected token from the request transaction
   always_comb begin
      head        = '0;
      head.valid  = req_ch.valid && !busy_ff;
      head.mode   = req_ch.mode;
      head.key    = {req_ch.slot, req_ch.channel};
      head.is_daq = req_ch.is_daq;
      head.seq    = req_ch.sequence_req;
   end

   assign chain[0] = head;

   // Row of entry cells
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      cbsm_cell #(
         .INDEX    (g),
         .SEQ_BITS (SEQ_BITS)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .tok_up (chain[g]),
         .tok_dn (chain[g+1])
      );
   end

   for (genvar g = 0; g <= CAPACITY; g++) begin : g_vld
      assign tok_valid_vec[g] = chain[g].valid;
   end

   // Form the response from the token leaving the chain
   always_comb begin
      rsp_in = '0;
      if (tail.done) begin
         rsp_in.status       = tail.status;
         rsp_in.entry_index  = tail.index;
         rsp_in.block_count  = tail.blocks;
         rsp_in.lost_count   = tail.lost;
         rsp_in.gap_seen     = tail.marks[MARK_GAP_BIT];
         rsp_in.updated_seen = tail.marks[MARK_UPD_BIT];
      end else begin
         case (tail.mode)
            MODE_RECORD: rsp_in.status = STATUS_FULL;
            MODE_CLEAR:  rsp_in.status = STATUS_UPDATED;
            default:     rsp_in.status = STATUS_NOT_FOUND;
         endcase
      end
   end

   // Track busy and output register occupancy
   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (tail.valid && !stall) begin
         rsp_valid_in = 1'b1;
         busy_in      = 1'b0;
      end
      if (head.valid) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (tail.valid && !stall) begin
            rsp_ff <= rsp_in;
         end
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_ff.status;
   assign rsp_ch.entry_index  = rsp_ff.entry_index;
   assign rsp_ch.block_count  = rsp_ff.block_count;
   assign rsp_ch.lost_count   = rsp_ff.lost_count;
   assign rsp_ch.gap_seen     = rsp_ff.gap_seen;
   assign rsp_ch.updated_seen = rsp_ff.updated_seen;

   // At most one transaction travels the chain
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones(tok_valid_vec) <= 1)
      else $error("more than one token in the cell chain");

   // An idle block has no token in flight
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (tok_valid_vec[CAPACITY:1] == '0))
      else $error("token in chain while not busy");

   // A stalled token stays at the tail
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      stall |=> tail.valid)
      else $error("stalled token lost");

   // A token leaving the chain lands in the output register
   a_tail_load: assert property (@(posedge clock) disable iff (reset)
      (tail.valid && !stall) |=> (rsp_valid_ff && !busy_ff))
      else $error("finished token did not reach the output register");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the channel block sequence monitor.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import cbsm_pkg::*;

   localparam int HALF_PERIOD   = 2;
   localparam int RESET_CYCLES  = 11;
   localparam int TABLE_DEPTH   = 32;
   localparam int RANDOM_ITEMS  = 1300;
   localparam int DRAIN_CYCLES  = 100;
   localparam int WATCHDOG_NS   = 2_000_000;

   // Mode value the block has no use for
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct {
      logic [MODE_W-1:0]    mode;
      logic [SLOT_W-1:0]    slot;
      logic [CHANNEL_W-1:0] channel;
      logic                 is_daq;
      logic [SEQ_REQ_W-1:0] seq;
   } descriptor_type;

   logic clock = 1'b0;
   logic reset;

   cbsm_req_if req_if ();
   cbsm_rsp_if rsp_if ();

   channel_block_sequence_monitor uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always #(HALF_PERIOD) clock = ~clock;

   descriptor_type pending_descriptors[$];
   rsp_type        expected_stats[$];
   int             failures = 0;
   int             descriptors_queued = 0;
   logic           req_fire = 1'b0;

   // Shadow copy of the statistics table
   logic                 tbl_valid    [TABLE_DEPTH];
   logic [KEY_W-1:0]     tbl_key      [TABLE_DEPTH];
   logic [COUNT_W-1:0]   tbl_blocks   [TABLE_DEPTH];
   logic [COUNT_W-1:0]   tbl_lost     [TABLE_DEPTH];
   logic [SEQ_REQ_W-1:0] tbl_last_seq [TABLE_DEPTH];
   logic [MARKS_W-1:0]   tbl_marks    [TABLE_DEPTH];
   int                   tbl_used = 0;

   // Stimulus-side view of the last acquisition sequence sent per key
   logic [SEQ_REQ_W-1:0] sent_seq [1 << KEY_W];

   function automatic logic [COUNT_W-1:0] sat_bump(logic [COUNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // Apply one descriptor to the shadow table and return the statistics it reports
   function automatic rsp_type track_descriptor(descriptor_type d);
      rsp_type          r;
      logic [KEY_W-1:0] key;
      int               hit;
      int               i;
      r   = '0;
      key = {d.slot, d.channel};
      hit = -1;
      for (i = 0; i < tbl_used; i++)
         if (hit < 0 && tbl_valid[i] && tbl_key[i] == key)
            hit = i;
      case (d.mode)
         MODE_RECORD: begin
            if (hit >= 0) begin
               tbl_blocks[hit] = sat_bump(tbl_blocks[hit]);
               tbl_marks[hit][MARK_UPD_BIT] = 1'b1;
               if (d.is_daq) begin
                  if (d.seq != SEQ_REQ_W'(tbl_last_seq[hit] + 1'b1)) begin
                     tbl_marks[hit][MARK_GAP_BIT] = 1'b1;
                     tbl_lost[hit] = sat_bump(tbl_lost[hit]);
                  end
                  tbl_last_seq[hit] = d.seq;
               end
               r.status       = STATUS_UPDATED;
               r.entry_index  = ENTRY_INDEX_W'(hit);
               r.block_count  = tbl_blocks[hit];
               r.lost_count   = tbl_lost[hit];
               r.gap_seen     = tbl_marks[hit][MARK_GAP_BIT];
               r.updated_seen = tbl_marks[hit][MARK_UPD_BIT];
            end else if (tbl_used >= TABLE_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               tbl_valid[tbl_used]    = 1'b1;
               tbl_key[tbl_used]      = key;
               tbl_blocks[tbl_used]   = COUNT_W'(1);
               tbl_lost[tbl_used]     = '0;
               tbl_last_seq[tbl_used] = d.seq;
               tbl_marks[tbl_used]    = '0;
               tbl_marks[tbl_used][MARK_UPD_BIT] = 1'b1;
               r.status       = STATUS_NEW;
               r.entry_index  = ENTRY_INDEX_W'(tbl_used);
               r.block_count  = COUNT_W'(1);
               r.updated_seen = 1'b1;
               tbl_used++;
            end
         end
         MODE_READ: begin
            if (hit < 0) begin
               r.status = STATUS_NOT_FOUND;
            end else begin
               r.status       = STATUS_UPDATED;
               r.entry_index  = ENTRY_INDEX_W'(hit);
               r.block_count  = tbl_blocks[hit];
               r.lost_count   = tbl_lost[hit];
               r.gap_seen     = tbl_marks[hit][MARK_GAP_BIT];
               r.updated_seen = tbl_marks[hit][MARK_UPD_BIT];
               tbl_marks[hit] = '0;
            end
         end
         MODE_CLEAR: begin
            for (i = 0; i < TABLE_DEPTH; i++)
               tbl_valid[i] = 1'b0;
            tbl_used = 0;
            r.status = STATUS_UPDATED;
         end
         default: begin
            r.status = STATUS_NOT_FOUND;
         end
      endcase
      return r;
   endfunction

   function automatic void check_field(string name, logic [COUNT_W-1:0] want,
                                       logic [COUNT_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         failures++;
      end
   endfunction

   function automatic void queue_descriptor(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                                            logic is_daq, logic [SEQ_REQ_W-1:0] seq);
      descriptor_type d;
      d.mode    = mode;
      d.slot    = key[KEY_W-1:CHANNEL_W];
      d.channel = key[CHANNEL_W-1:0];
      d.is_daq  = is_daq;
      d.seq     = seq;
      pending_descriptors = {pending_descriptors, d};
      if (mode != MODE_UNUSED)
         descriptors_queued++;
   endfunction

   // Record a block on a key, mostly in sequence, now and then with a gap
   function automatic void queue_record(logic [KEY_W-1:0] key);
      logic                 daq;
      logic [SEQ_REQ_W-1:0] seq;
      daq = ($urandom_range(0, 4) != 0);
      if (daq && $urandom_range(0, 99) < 85)
         seq = sent_seq[key] + 1'b1;
      else
         seq = SEQ_REQ_W'($urandom_range(0, 255));
      if (daq)
         sent_seq[key] = seq;
      queue_descriptor(MODE_RECORD, key, daq, seq);
   endfunction

   // Driver: present pending transactions in bursts with random gaps
   int burst_left = 0;
   int gap_left   = 0;

   always @(negedge clock) begin : drive_requests
      descriptor_type d;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fire) begin
         if (gap_left > 0 || pending_descriptors.size() == 0) begin
            if (gap_left > 0)
               gap_left--;
            req_if.valid <= 1'b0;
         end else begin
            d = pending_descriptors.pop_front();
            req_if.valid        <= 1'b1;
            req_if.mode         <= d.mode;
            req_if.slot         <= d.slot;
            req_if.channel      <= d.channel;
            req_if.is_daq       <= d.is_daq;
            req_if.sequence_req <= d.seq;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 60);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
      end
   end

   // Response sink: switch between free flow, light stalls and long stalls
   int stall_style = 0;
   int style_left  = 0;
   int stall_left  = 0;

   always @(negedge clock) begin : drive_ready
      logic rdy;
      if (style_left == 0) begin
         stall_style = $urandom_range(0, 2);
         style_left  = $urandom_range(50, 400);
      end else begin
         style_left--;
      end
      case (stall_style)
         0: rdy = 1'b1;
         1: rdy = ($urandom_range(0, 3) != 0);
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rdy = 1'b0;
            end else begin
               rdy = 1'b1;
               stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
            end
         end
      endcase
      rsp_if.ready <= rdy;
   end

   // Monitor: predict on each accepted request, check each accepted response
   always @(posedge clock) begin : monitor
      descriptor_type d;
      rsp_type        want;
      req_fire <= !reset && req_if.valid && req_if.ready;
      if (!reset && req_if.valid && req_if.ready) begin
         d.mode    = req_if.mode;
         d.slot    = req_if.slot;
         d.channel = req_if.channel;
         d.is_daq  = req_if.is_daq;
         d.seq     = req_if.sequence_req;
         expected_stats = {expected_stats, track_descriptor(d)};
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_stats.size() == 0) begin
            $error("response transaction with no request outstanding");
            failures++;
         end else begin
            want = expected_stats.pop_front();
            check_field("status", COUNT_W'(want.status), COUNT_W'(rsp_if.status));
            check_field("entry_index", COUNT_W'(want.entry_index),
                        COUNT_W'(rsp_if.entry_index));
            check_field("block_count", want.block_count, rsp_if.block_count);
            check_field("lost_count", want.lost_count, rsp_if.lost_count);
            check_field("gap_seen", COUNT_W'(want.gap_seen), COUNT_W'(rsp_if.gap_seen));
            check_field("updated_seen", COUNT_W'(want.updated_seen),
                        COUNT_W'(rsp_if.updated_seen));
         end
      end
   end

   // Stimulus, reset and end of run
   initial begin : stimulus
      logic [KEY_W-1:0] pool [48];
      int               pool_size;
      int               phase_len;
      int               k;
      int               roll;
      logic [KEY_W-1:0] key;

      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.mode         = MODE_RECORD;
      req_if.slot         = '0;
      req_if.channel      = '0;
      req_if.is_daq       = 1'b0;
      req_if.sequence_req = '0;
      rsp_if.ready        = 1'b0;
      for (k = 0; k < (1 << KEY_W); k++)
         sent_seq[k] = '0;
      for (k = 0; k < TABLE_DEPTH; k++)
         tbl_valid[k] = 1'b0;

      // Directed: empty table, wrap, gaps, untracked blocks, reads, clear
      queue_descriptor(MODE_READ,   8'h00, 1'b0, 8'h00);
      queue_descriptor(MODE_UNUSED, 8'h00, 1'b0, 8'h00);
      queue_descriptor(MODE_CLEAR,  8'h00, 1'b0, 8'h00);
      queue_descriptor(MODE_RECORD, 8'h00, 1'b1, 8'hFF);
      queue_descriptor(MODE_RECORD, 8'h00, 1'b1, 8'h00);
      queue_descriptor(MODE_RECORD, 8'h00, 1'b1, 8'h05);
      queue_descriptor(MODE_RECORD, 8'h00, 1'b0, 8'hAA);
      queue_descriptor(MODE_RECORD, 8'h00, 1'b1, 8'h06);
      queue_descriptor(MODE_READ,   8'h00, 1'b0, 8'h00);
      queue_descriptor(MODE_READ,   8'h00, 1'b1, 8'hFF);
      queue_descriptor(MODE_RECORD, 8'hFF, 1'b0, 8'h55);
      queue_descriptor(MODE_RECORD, 8'hFF, 1'b1, 8'h56);
      queue_descriptor(MODE_RECORD, 8'hFF, 1'b1, 8'h56);
      queue_descriptor(MODE_READ,   8'hFF, 1'b0, 8'h00);
      queue_descriptor(MODE_READ,   8'h93, 1'b0, 8'h00);
      queue_descriptor(MODE_UNUSED, 8'hFF, 1'b1, 8'hFF);
      queue_descriptor(MODE_CLEAR,  8'hFF, 1'b1, 8'hFF);
      queue_descriptor(MODE_READ,   8'h00, 1'b0, 8'h00);
      queue_descriptor(MODE_RECORD, 8'h00, 1'b1, 8'h00);
      queue_descriptor(MODE_RECORD, 8'h00, 1'b1, 8'h01);
      sent_seq[8'h00] = 8'h01;

      // Random phases: a few busy keys for long sequences, or many keys to fill the table
      while (descriptors_queued < RANDOM_ITEMS) begin
         pool_size = ($urandom_range(0, 2) == 0) ? $urandom_range(33, 48)
                                                 : $urandom_range(1, 8);
         for (k = 0; k < pool_size; k++)
            pool[k] = KEY_W'($urandom_range(0, 255));
         phase_len = $urandom_range(40, 200);
         for (k = 0; k < phase_len; k++) begin
            key  = pool[$urandom_range(0, pool_size - 1)];
            roll = $urandom_range(0, 99);
            if (roll < 70)
               queue_record(key);
            else if (roll < 88)
               queue_descriptor(MODE_READ, key, 1'($urandom_range(0, 1)),
                                SEQ_REQ_W'($urandom_range(0, 255)));
            else if (roll < 95)
               queue_descriptor(MODE_READ, KEY_W'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1)),
                                SEQ_REQ_W'($urandom_range(0, 255)));
            else if (roll < 97)
               queue_descriptor(MODE_UNUSED, KEY_W'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1)),
                                SEQ_REQ_W'($urandom_range(0, 255)));
            else
               queue_descriptor(MODE_RECORD, KEY_W'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1)),
                                SEQ_REQ_W'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 2) != 0)
            queue_descriptor(MODE_CLEAR, KEY_W'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)),
                             SEQ_REQ_W'($urandom_range(0, 255)));
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain: all requests taken, all responses in, then let the chain settle
      while (pending_descriptors.size() != 0 || req_if.valid)
         @(posedge clock);
      while (expected_stats.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #(WATCHDOG_NS);
      $display("Test completed with failures");
      $finish;
   end

endmodule

>>> sim.f
sv/cbsm_pkg.sv
sv/cbsm_if.sv
sv/cbsm_cell.sv
sv/channel_block_sequence_monitor.sv
tb/sv/testbench.sv
